>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the congestion window unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

>>> src/tcpr_pkg.sv
// ----------------------------------------------------------------------------
// tcpr_pkg
// Widths, codes, reset values and helpers of the congestion window unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned SEG_W  = 16;
  localparam int unsigned SEG3_W = 18;
  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] KIND_NEW_ACK = 2'd0;
  localparam logic [1:0] KIND_DUP_ACK = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  localparam logic [1:0] REG_SEG_SIZE         = 2'd0;
  localparam logic [1:0] REG_INITIAL_CWND     = 2'd1;
  localparam logic [1:0] REG_INITIAL_SSTHRESH = 2'd2;

  localparam logic [15:0] DUP_THRESHOLD = 16'd3;

  localparam logic [15:0] SEG_SIZE_RST         = 16'd1460;
  localparam logic [31:0] INITIAL_CWND_RST     = 32'd1460;
  localparam logic [31:0] INITIAL_SSTHRESH_RST = 32'd65535;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] halved_thr(input logic [31:0] window,
                                             input logic [15:0] seg);
    logic [31:0] half;
    logic [31:0] floor2;
    half   = {1'b0, window[31:1]};
    floor2 = {15'd0, seg, 1'b0};
    return (half > floor2) ? half : floor2;
  endfunction

endpackage

`default_nettype wire

>>> src/tcpr_if.sv
// ----------------------------------------------------------------------------
// tcpr_if
// Event and update channels of the congestion window unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcpr_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] dup_count;
  logic [31:0] window_bytes;

  modport source (output valid, output kind, output dup_count, output window_bytes,
                  input ready);
  modport sink   (input valid, input kind, input dup_count, input window_bytes,
                  output ready);
endinterface

interface tcpr_upd_if;
  logic        valid;
  logic        ready;
  logic [31:0] cwnd_bytes;
  logic [31:0] ssthresh_bytes;
  logic        in_recovery;
  logic        do_retransmit;
  logic        send_pending;
  logic        backoff_timer;
  logic        rewind_send;

  modport source (output valid, output cwnd_bytes, output ssthresh_bytes,
                  output in_recovery, output do_retransmit, output send_pending,
                  output backoff_timer, output rewind_send, input ready);
  modport sink   (input valid, input cwnd_bytes, input ssthresh_bytes,
                  input in_recovery, input do_retransmit, input send_pending,
                  input backoff_timer, input rewind_send, output ready);
endinterface

`default_nettype wire

>>> src/tcpr_div.sv
// ----------------------------------------------------------------------------
// tcpr_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tcpr_pkg::DATA_W-1:0] dividend,
  input  logic [tcpr_pkg::DATA_W-1:0] divisor,
  output logic                        done,
  output logic [tcpr_pkg::DATA_W-1:0] quotient
);

  logic [tcpr_pkg::DATA_W-1:0] rem;
  logic [tcpr_pkg::DATA_W-1:0] quo;
  logic [tcpr_pkg::CNT_W-1:0]  cnt;
  logic                        busy;
  logic [tcpr_pkg::DATA_W:0]   trial;
  logic [tcpr_pkg::DATA_W:0]   diff;

  assign trial    = {rem, quo[tcpr_pkg::DATA_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        cnt  <= tcpr_pkg::CNT_W'(tcpr_pkg::DATA_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[tcpr_pkg::DATA_W]) begin
          rem <= diff[tcpr_pkg::DATA_W-1:0];
        end else begin
          rem <= trial[tcpr_pkg::DATA_W-1:0];
        end
        quo <= {quo[tcpr_pkg::DATA_W-2:0], ~diff[tcpr_pkg::DATA_W]};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> src/tcp_reno_congestion_window_unit.sv
// ----------------------------------------------------------------------------
// tcp_reno_congestion_window_unit
// Reno congestion window, slow start threshold and fast recovery tracking.
// ----------------------------------------------------------------------------
// Usage:
//   evt carries one ack or timeout event per beat (kind, dup_count,
//   window_bytes); upd returns one beat per event with the window, the
//   threshold, the recovery flag and the retransmit, send, backoff and
//   rewind requests.
//   The APB port holds seg_size (0x0), initial_cwnd (0x4) and
//   initial_ssthresh (0x8); writing an initial value also loads the live
//   register. Write only while the unit is idle.
//   Each event passes through a start state, a divide state for a new ack
//   in congestion avoidance with a nonzero cwnd (bit-serial divider, 32
//   steps, forming seg_size*seg_size/cwnd) and a commit state. One event
//   is in flight at a time; the next is taken in the cycle after the
//   result is registered.
//   A result waiting on upd does not block the next accept; a finished
//   event holds in its commit cycle until the update register is free.
//   Reset loads the reset register values, clears recovery and drops any
//   pending update.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcp_reno_congestion_window_unit (
  input  logic                        clk,
  input  logic                        rst,
  tcpr_evt_if.sink                    evt,
  tcpr_upd_if.source                  upd,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcpr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_START, ST_DIV, ST_COMMIT} state_t;

  state_t      state;
  logic [15:0] seg_size;
  logic [31:0] initial_cwnd;
  logic [31:0] initial_ssthresh;
  logic [31:0] cwnd;
  logic [31:0] ssth;
  logic        rec;

  logic [1:0]  kind_q;
  logic [15:0] dups_q;
  logic [31:0] win_q;
  logic [31:0] thr;
  logic [tcpr_pkg::SEG3_W-1:0] seg3;
  logic        below;

  logic        needs_div;
  logic        div_start;
  logic        div_done;
  logic [31:0] quot;
  logic [31:0] seg_sq;
  logic [31:0] seg_ext;
  logic [31:0] ca_add;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic [31:0] sum;
  logic        commit_go;
  logic        timeout_commit;
  logic        wr_en;
  logic [1:0]  reg_idx;

  logic [31:0] cwnd_next;
  logic [31:0] ssth_next;
  logic        rec_next;
  logic        retx_next;
  logic        pend_next;
  logic        back_next;
  logic        rew_next;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[tcpr_pkg::ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite;
  assign evt.ready = (state == ST_IDLE);
  assign commit_go = (state == ST_COMMIT) && (!upd.valid || upd.ready);
  assign timeout_commit = commit_go && (kind_q == tcpr_pkg::KIND_TIMEOUT);

  assign needs_div = (kind_q == tcpr_pkg::KIND_NEW_ACK) && !rec && !(cwnd < ssth)
                     && (cwnd != 32'd0);
  assign div_start = (state == ST_START) && needs_div;
  assign seg_sq    = {16'd0, seg_size} * {16'd0, seg_size};
  assign seg_ext   = {16'd0, seg_size};
  assign ca_add    = ((cwnd == 32'd0) || (quot <= 32'd1)) ? 32'd1 : quot;

  tcpr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (seg_sq),
    .divisor  (cwnd),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      tcpr_pkg::REG_SEG_SIZE:         prdata = seg_ext;
      tcpr_pkg::REG_INITIAL_CWND:     prdata = initial_cwnd;
      tcpr_pkg::REG_INITIAL_SSTHRESH: prdata = initial_ssthresh;
      default:                        prdata = 32'd0;
    endcase
  end

  // share one saturating adder across all window steps
  always_comb begin
    add_a = cwnd;
    add_b = seg_ext;
    if ((kind_q == tcpr_pkg::KIND_DUP_ACK) && !rec) begin
      add_a = thr;
      add_b = {{(32 - tcpr_pkg::SEG3_W){1'b0}}, seg3};
    end else if ((kind_q == tcpr_pkg::KIND_NEW_ACK) && !rec && !below) begin
      add_b = ca_add;
    end
  end

  assign sum = tcpr_pkg::sat_add(add_a, add_b);

  always_comb begin
    cwnd_next = cwnd;
    ssth_next = ssth;
    rec_next  = rec;
    retx_next = 1'b0;
    pend_next = 1'b0;
    back_next = 1'b0;
    rew_next  = 1'b0;
    unique case (kind_q)
      tcpr_pkg::KIND_NEW_ACK: begin
        if (rec) begin
          cwnd_next = ssth;
          rec_next  = 1'b0;
        end else begin
          cwnd_next = sum;
        end
      end
      tcpr_pkg::KIND_DUP_ACK: begin
        if (rec) begin
          cwnd_next = sum;
          pend_next = 1'b1;
        end else if (dups_q == tcpr_pkg::DUP_THRESHOLD) begin
          rec_next  = 1'b1;
          ssth_next = thr;
          cwnd_next = sum;
          retx_next = 1'b1;
        end
      end
      tcpr_pkg::KIND_TIMEOUT: begin
        ssth_next = thr;
        cwnd_next = seg_ext;
        rec_next  = 1'b0;
        retx_next = 1'b1;
        back_next = 1'b1;
        rew_next  = 1'b1;
      end
      default: begin
        cwnd_next = cwnd;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      seg_size         <= tcpr_pkg::SEG_SIZE_RST;
      initial_cwnd     <= tcpr_pkg::INITIAL_CWND_RST;
      initial_ssthresh <= tcpr_pkg::INITIAL_SSTHRESH_RST;
      cwnd             <= tcpr_pkg::INITIAL_CWND_RST;
      ssth             <= tcpr_pkg::INITIAL_SSTHRESH_RST;
      rec              <= 1'b0;
      upd.valid        <= 1'b0;
    end else begin
      if (upd.valid && upd.ready && !commit_go) begin
        upd.valid <= 1'b0;
      end
      if (wr_en) begin
        unique case (reg_idx)
          tcpr_pkg::REG_SEG_SIZE: begin
            seg_size <= pwdata[15:0];
          end
          tcpr_pkg::REG_INITIAL_CWND: begin
            initial_cwnd <= pwdata;
            cwnd         <= pwdata;
          end
          tcpr_pkg::REG_INITIAL_SSTHRESH: begin
            initial_ssthresh <= pwdata;
            ssth             <= pwdata;
          end
          default: begin
            seg_size <= seg_size;
          end
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (evt.valid) begin
            kind_q <= evt.kind;
            dups_q <= evt.dup_count;
            win_q  <= evt.window_bytes;
            state  <= ST_START;
          end
        end
        ST_START: begin
          thr   <= tcpr_pkg::halved_thr(win_q, seg_size);
          seg3  <= {2'b00, seg_size} + {1'b0, seg_size, 1'b0};
          below <= (cwnd < ssth);
          state <= needs_div ? ST_DIV : ST_COMMIT;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit_go) begin
            cwnd               <= cwnd_next;
            ssth               <= ssth_next;
            rec                <= rec_next;
            upd.valid          <= 1'b1;
            upd.cwnd_bytes     <= cwnd_next;
            upd.ssthresh_bytes <= ssth_next;
            upd.in_recovery    <= rec_next;
            upd.do_retransmit  <= retx_next;
            upd.send_pending   <= pend_next;
            upd.backoff_timer  <= back_next;
            upd.rewind_send    <= rew_next;
            state              <= ST_IDLE;
          end
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_starts, clk, rst, evt.valid && evt.ready, state == ST_START)
  `ASSERT_IMPLIES(a_div_done_in_div, clk, rst, div_done, state == ST_DIV)
  `ASSERT_NEXT(a_timeout_leaves_recovery, clk, rst, timeout_commit, !rec && upd.valid && upd.do_retransmit)

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Reno congestion window unit. Ack and timeout
// beats are fed through the event channel under random stalls on both sides;
// a cycle-free predictor keeps its own window, threshold and recovery state
// and every update beat is compared field by field in arrival order. APB
// writes change the segment size and the initial window and threshold
// between phases, covering extreme and zero settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam logic [1:0] REG_RESERVED  = 2'd3;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 134;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] dup_count;
    logic [31:0] window_bytes;
    logic        hold_for_drain;
  } ack_event_t;

  typedef struct packed {
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic        recovery;
    logic        retransmit;
    logic        pending;
    logic        backoff;
    logic        rewind;
  } window_update_t;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [tcpr_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  tcpr_evt_if evt();
  tcpr_upd_if upd();

  tcp_reno_congestion_window_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .evt     (evt),
    .upd     (upd),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ack_event_t     pending_events[$];
  window_update_t expected_updates[$];
  ack_event_t     next_event;
  window_update_t want_upd;

  logic [15:0] seg_q;
  logic [31:0] cwnd_q;
  logic [31:0] ssthr_q;
  logic        recovery_q;

  int  send_idle_pct;
  int  recv_idle_pct;
  int  items_queued;
  int  mismatches;
  int  quiet_cycles;
  bit  evt_beat;
  bit  upd_beat;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] clamp_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] total;
    total = {1'b0, a} + {1'b0, b};
    if (total > 33'h0_FFFF_FFFF) return 32'hFFFF_FFFF;
    return total[31:0];
  endfunction

  function automatic logic [31:0] loss_threshold(input logic [31:0] window);
    logic [31:0] half;
    logic [31:0] floor_two;
    half      = window >> 1;
    floor_two = {16'd0, seg_q} << 1;
    return (half > floor_two) ? half : floor_two;
  endfunction

  task automatic predict_window_update(input ack_event_t ev);
    window_update_t want;
    logic [63:0]    quot;
    logic [31:0]    step;
    want = '0;
    case (ev.kind)
      tcpr_pkg::KIND_NEW_ACK: begin
        if (recovery_q) begin
          cwnd_q     = ssthr_q;
          recovery_q = 1'b0;
        end else if (cwnd_q < ssthr_q) begin
          cwnd_q = clamp_sum(cwnd_q, {16'd0, seg_q});
        end else begin
          step = 32'd1;
          if (cwnd_q != 32'd0) begin
            quot = ({48'd0, seg_q} * {48'd0, seg_q}) / {32'd0, cwnd_q};
            if (quot > 64'd1) step = quot[31:0];
          end
          cwnd_q = clamp_sum(cwnd_q, step);
        end
      end
      tcpr_pkg::KIND_DUP_ACK: begin
        if (recovery_q) begin
          cwnd_q       = clamp_sum(cwnd_q, {16'd0, seg_q});
          want.pending = 1'b1;
        end else if (ev.dup_count == tcpr_pkg::DUP_THRESHOLD) begin
          recovery_q      = 1'b1;
          ssthr_q         = loss_threshold(ev.window_bytes);
          cwnd_q          = clamp_sum(ssthr_q, {16'd0, seg_q} * 32'd3);
          want.retransmit = 1'b1;
        end
      end
      tcpr_pkg::KIND_TIMEOUT: begin
        ssthr_q         = loss_threshold(ev.window_bytes);
        cwnd_q          = {16'd0, seg_q};
        recovery_q      = 1'b0;
        want.retransmit = 1'b1;
        want.backoff    = 1'b1;
        want.rewind     = 1'b1;
      end
      default: ;
    endcase
    want.cwnd     = cwnd_q;
    want.ssthresh = ssthr_q;
    want.recovery = recovery_q;
    expected_updates.push_back(want);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // drive event beats and update backpressure
  always @(negedge clk) begin
    if (!rst) begin
      if (evt.valid && !evt_beat) begin
      end else if (pending_events.size() != 0 &&
                   !(pending_events[0].hold_for_drain && expected_updates.size() != 0) &&
                   $urandom_range(99) >= send_idle_pct) begin
        next_event       = pending_events.pop_front();
        evt.valid        <= 1'b1;
        evt.kind         <= next_event.kind;
        evt.dup_count    <= next_event.dup_count;
        evt.window_bytes <= next_event.window_bytes;
      end else begin
        evt.valid <= 1'b0;
      end
      upd.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // accept beats, predict, check, watch for a hang
  always @(posedge clk) begin
    evt_beat = evt.valid && evt.ready;
    upd_beat = !rst && upd.valid && upd.ready;
    if (evt_beat) begin
      predict_window_update({evt.kind, evt.dup_count, evt.window_bytes, 1'b0});
    end
    if (upd_beat) begin
      if (expected_updates.size() == 0) begin
        report_mismatch("unexpected update beat", upd.cwnd_bytes, 32'd0);
      end else begin
        want_upd = expected_updates.pop_front();
        if (upd.cwnd_bytes !== want_upd.cwnd)
          report_mismatch("cwnd_bytes", upd.cwnd_bytes, want_upd.cwnd);
        if (upd.ssthresh_bytes !== want_upd.ssthresh)
          report_mismatch("ssthresh_bytes", upd.ssthresh_bytes, want_upd.ssthresh);
        if (upd.in_recovery !== want_upd.recovery)
          report_mismatch("in_recovery", {31'd0, upd.in_recovery},
                          {31'd0, want_upd.recovery});
        if (upd.do_retransmit !== want_upd.retransmit)
          report_mismatch("do_retransmit", {31'd0, upd.do_retransmit},
                          {31'd0, want_upd.retransmit});
        if (upd.send_pending !== want_upd.pending)
          report_mismatch("send_pending", {31'd0, upd.send_pending},
                          {31'd0, want_upd.pending});
        if (upd.backoff_timer !== want_upd.backoff)
          report_mismatch("backoff_timer", {31'd0, upd.backoff_timer},
                          {31'd0, want_upd.backoff});
        if (upd.rewind_send !== want_upd.rewind)
          report_mismatch("rewind_send", {31'd0, upd.rewind_send},
                          {31'd0, want_upd.rewind});
      end
    end
    if (evt_beat || upd_beat) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      tcpr_pkg::REG_SEG_SIZE:         seg_q   = value[15:0];
      tcpr_pkg::REG_INITIAL_CWND:     cwnd_q  = value;
      tcpr_pkg::REG_INITIAL_SSTHRESH: ssthr_q = value;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_event(input logic [1:0] kind, input logic [15:0] dups,
                             input logic [31:0] window, input logic hold);
    pending_events.push_back({kind, dups, window, hold});
    items_queued++;
  endtask

  task automatic wait_for_quiet();
    while (pending_events.size() != 0 || evt.valid || expected_updates.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] any_window();
    case ($urandom_range(3))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 200000);
      default: begin
        case ($urandom_range(2))
          0:       return 32'd0;
          1:       return 32'd1;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  task automatic configure_random();
    logic [15:0] seg;
    logic [31:0] cwnd;
    logic [31:0] ssthr;
    case ($urandom_range(4))
      0:       seg = 16'd1;
      1:       seg = 16'hFFFF;
      2:       seg = 16'd1460;
      3:       seg = 16'd536;
      default: seg = 16'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(3))
      0:       cwnd = seg * $urandom_range(1, 10);
      1:       cwnd = $urandom;
      2:       cwnd = $urandom_range(1, 100000);
      default: cwnd = 32'd1;
    endcase
    case ($urandom_range(3))
      0:       ssthr = $urandom_range(2000, 200000);
      1:       ssthr = $urandom;
      2:       ssthr = 32'hFFFF_FFFF;
      default: ssthr = 32'd1;
    endcase
    write_register(tcpr_pkg::REG_SEG_SIZE, {16'd0, seg});
    write_register(tcpr_pkg::REG_INITIAL_CWND, cwnd);
    write_register(tcpr_pkg::REG_INITIAL_SSTHRESH, ssthr);
  endtask

  task automatic queue_random_burst();
    int   r;
    int   n;
    logic hold;
    r    = $urandom_range(99);
    hold = ($urandom_range(49) == 0);
    if (r < 40) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        queue_event(tcpr_pkg::KIND_NEW_ACK, 16'($urandom), any_window(), hold && i == 0);
    end else if (r < 70) begin
      n = $urandom_range(1, 6);
      for (int i = 1; i <= n; i++)
        queue_event(tcpr_pkg::KIND_DUP_ACK, 16'(i), any_window(), hold && i == 1);
      if ($urandom_range(3) != 0)
        queue_event(tcpr_pkg::KIND_NEW_ACK, 16'($urandom), any_window(), 1'b0);
    end else if (r < 80) begin
      queue_event(tcpr_pkg::KIND_TIMEOUT, 16'($urandom), any_window(), hold);
    end else if (r < 92) begin
      queue_event(tcpr_pkg::KIND_DUP_ACK, 16'($urandom), any_window(), hold);
    end else begin
      queue_event(KIND_RESERVED, 16'($urandom), any_window(), hold);
    end
  endtask

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    evt.valid        = 1'b0;
    evt.kind         = tcpr_pkg::KIND_NEW_ACK;
    evt.dup_count    = '0;
    evt.window_bytes = '0;
    upd.ready        = 1'b0;
    seg_q            = tcpr_pkg::SEG_SIZE_RST;
    cwnd_q           = tcpr_pkg::INITIAL_CWND_RST;
    ssthr_q          = tcpr_pkg::INITIAL_SSTHRESH_RST;
    recovery_q       = 1'b0;
    send_idle_pct    = 37;
    recv_idle_pct    = 67;
    items_queued     = 0;
    mismatches       = 0;
    quiet_cycles     = 0;
    evt_beat         = 1'b0;
    upd_beat         = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset settings: slow start, recovery entry and exit, avoidance, timeouts
    queue_event(tcpr_pkg::KIND_NEW_ACK, 16'd0, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_DUP_ACK, 16'd0, 32'hFFFF_FFFF, 1'b0);
    queue_event(tcpr_pkg::KIND_DUP_ACK, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_event(tcpr_pkg::KIND_DUP_ACK, tcpr_pkg::DUP_THRESHOLD, 32'hFFFF_FFFF, 1'b0);
    queue_event(tcpr_pkg::KIND_DUP_ACK, 16'd4, 32'd0, 1'b0);
    queue_event(KIND_RESERVED, 16'd0, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_NEW_ACK, 16'hFFFF, 32'd0, 1'b1);
    queue_event(tcpr_pkg::KIND_NEW_ACK, 16'd0, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_TIMEOUT, 16'd0, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_NEW_ACK, 16'd0, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_NEW_ACK, 16'd0, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_DUP_ACK, tcpr_pkg::DUP_THRESHOLD, 32'd1, 1'b0);
    queue_event(tcpr_pkg::KIND_TIMEOUT, 16'd0, 32'hFFFF_FFFE, 1'b0);
    queue_event(KIND_RESERVED, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    wait_for_quiet();

    // largest segment, saturated window, lowest threshold
    write_register(tcpr_pkg::REG_SEG_SIZE, 32'h0000_FFFF);
    write_register(tcpr_pkg::REG_INITIAL_CWND, 32'hFFFF_FFFF);
    write_register(tcpr_pkg::REG_INITIAL_SSTHRESH, 32'd1);
    write_register(REG_RESERVED, 32'hFFFF_FFFF);
    queue_event(tcpr_pkg::KIND_NEW_ACK, 16'd0, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_DUP_ACK, tcpr_pkg::DUP_THRESHOLD, 32'hFFFF_FFFF, 1'b0);
    queue_event(tcpr_pkg::KIND_DUP_ACK, 16'd5, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_TIMEOUT, 16'd0, 32'hFFFF_FFFF, 1'b0);
    queue_event(tcpr_pkg::KIND_NEW_ACK, 16'd0, 32'd0, 1'b0);
    wait_for_quiet();

    // zero segment, zero window and zero threshold
    write_register(tcpr_pkg::REG_SEG_SIZE, 32'd0);
    write_register(tcpr_pkg::REG_INITIAL_CWND, 32'd0);
    write_register(tcpr_pkg::REG_INITIAL_SSTHRESH, 32'd0);
    queue_event(tcpr_pkg::KIND_NEW_ACK, 16'd0, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_NEW_ACK, 16'd0, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_TIMEOUT, 16'd0, 32'd3, 1'b0);
    queue_event(tcpr_pkg::KIND_NEW_ACK, 16'd0, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_DUP_ACK, tcpr_pkg::DUP_THRESHOLD, 32'd0, 1'b0);
    queue_event(tcpr_pkg::KIND_DUP_ACK, 16'd1, 32'd0, 1'b0);
    wait_for_quiet();

    // slow start step that saturates
    write_register(tcpr_pkg::REG_SEG_SIZE, 32'd1460);
    write_register(tcpr_pkg::REG_INITIAL_CWND, 32'hFFFF_FFF0);
    write_register(tcpr_pkg::REG_INITIAL_SSTHRESH, 32'hFFFF_FFFF);
    queue_event(tcpr_pkg::KIND_NEW_ACK, 16'd0, 32'd0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      wait_for_quiet();
      configure_random();
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int burst = items_queued + PHASE_ITEMS; items_queued < burst; )
        queue_random_burst();
    end

    wait_for_quiet();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
